>>> design/bea_pkg.sv
// Shared constants, types and codes for the button edge and auto-repeat block.
package bea_pkg;

  // Button table geometry.
  localparam int NUM_BUTTONS = 128;
  localparam int ADDR_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  // Field and register widths.
  localparam int INDEX_W = 7;
  localparam int COUNT_W = 15;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_INDEX_W = 1;
  localparam int ENTRY_W = COUNT_W + 1;
  localparam int STEP_W = $clog2(COUNT_W);

  // Hold counter wraps to zero past this value.
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = 15'd30000;

  // Register reset values.
  localparam logic [CFG_DATA_W-1:0] START_DELAY_RESET = 15'd24;
  localparam logic [CFG_DATA_W-1:0] REP_PERIOD_RESET = 15'd12;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_START_DELAY = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REP_PERIOD = 1'd1;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_DIV,
    S_HOLD
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_item;
    logic calc;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;
    logic div_done;
  } status_t;

endpackage

>>> design/bea_rem.sv
// Bit-serial remainder unit: one restoring division step per cycle.
module bea_rem (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bea_pkg::COUNT_W-1:0]  dividend,
  input  logic [bea_pkg::COUNT_W-1:0]  divisor,
  output logic                         done,
  output logic [bea_pkg::COUNT_W-1:0]  remainder
);

  logic                         busy;
  logic [bea_pkg::STEP_W-1:0]   step;
  logic [bea_pkg::COUNT_W-1:0]  dvd;
  logic [bea_pkg::COUNT_W-1:0]  dsr;
  logic [bea_pkg::COUNT_W-1:0]  rem;
  logic [bea_pkg::COUNT_W:0]    trial;
  logic [bea_pkg::COUNT_W:0]    trial_diff;
  logic                         trial_fits;

  // Shift in the next dividend bit and try a subtraction.
  always_comb begin
    trial = {rem, dvd[bea_pkg::COUNT_W-1]};
    trial_diff = trial - {1'b0, dsr};
    trial_fits = (trial >= {1'b0, dsr});
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == bea_pkg::STEP_W'(bea_pkg::COUNT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[bea_pkg::COUNT_W-2:0], 1'b0};
      rem <= trial_fits ? trial_diff[bea_pkg::COUNT_W-1:0] : trial[bea_pkg::COUNT_W-1:0];
    end
  end

  assign remainder = rem;

endmodule

>>> design/bea_datapath.sv
// Datapath: per-button state memory, counter update, repeat decision and result register.
module bea_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  bea_pkg::cmd_t                    cmd,
  output bea_pkg::status_t                 status,
  input  logic                             cfg_write,
  input  logic [bea_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bea_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [bea_pkg::INDEX_W-1:0]      button_index,
  input  logic                             button_pressed,
  output logic                             pressed_now,
  output logic                             rose,
  output logic                             fell,
  output logic                             repeat_pulse,
  output logic                             repeat_held
);

  // Configuration registers.
  logic [bea_pkg::CFG_DATA_W-1:0] start_delay;
  logic [bea_pkg::CFG_DATA_W-1:0] rep_period;

  // Per-button state: level and hold count, with a valid bit per entry.
  logic [bea_pkg::ENTRY_W-1:0]     mem [bea_pkg::NUM_BUTTONS];
  logic [bea_pkg::NUM_BUTTONS-1:0] entry_valid;
  logic [bea_pkg::ENTRY_W-1:0]     rd_data;
  logic                            rd_valid;

  // The item in progress.
  logic [bea_pkg::ADDR_W-1:0] item_addr;
  logic                       item_level;
  logic                       item_in_range;
  logic [bea_pkg::ADDR_W-1:0] in_addr;
  logic                       in_range;

  // Update logic.
  logic                      prev_level;
  logic [bea_pkg::COUNT_W-1:0] old_count;
  logic [bea_pkg::COUNT_W:0]   inc_count;
  logic [bea_pkg::COUNT_W-1:0] count_next;
  logic                      rose_c;
  logic                      fell_c;
  logic                      past_delay;
  logic                      held_c;
  logic [bea_pkg::COUNT_W-1:0] divisor;

  // Result held until the output register is free.
  logic res_level;
  logic res_rose;
  logic res_fell;
  logic res_pulse;
  logic res_held;

  // Remainder unit.
  logic                        div_start;
  logic                        div_done;
  logic [bea_pkg::COUNT_W-1:0] div_rem;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_delay <= bea_pkg::START_DELAY_RESET;
      rep_period <= bea_pkg::REP_PERIOD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bea_pkg::REG_START_DELAY: start_delay <= cfg_data;
        bea_pkg::REG_REP_PERIOD:  rep_period <= cfg_data;
      endcase
    end
  end

  // Index decode of the incoming item.
  assign in_range = (32'(button_index) < 32'(bea_pkg::NUM_BUTTONS));
  assign in_addr = bea_pkg::ADDR_W'(button_index);

  // Capture the item and read its state on a transfer.
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      item_addr <= in_addr;
      item_level <= button_pressed;
      item_in_range <= in_range;
      rd_data <= mem[in_addr];
      rd_valid <= entry_valid[in_addr];
    end
  end

  // Edge detection and hold counter update; an entry never written reads as zero.
  always_comb begin
    prev_level = rd_valid & rd_data[bea_pkg::COUNT_W];
    old_count = rd_valid ? rd_data[bea_pkg::COUNT_W-1:0] : '0;
    inc_count = {1'b0, old_count} + 1'b1;
    rose_c = item_level & ~prev_level;
    fell_c = prev_level & ~item_level;
    if (rose_c || fell_c) begin
      count_next = '0;
    end else if (item_level) begin
      count_next = (inc_count > {1'b0, bea_pkg::COUNT_LIMIT}) ? '0
                                                              : inc_count[bea_pkg::COUNT_W-1:0];
    end else begin
      count_next = old_count;
    end
    past_delay = item_level & ~rose_c & (count_next > start_delay);
    held_c = rose_c | past_delay;
    divisor = (rep_period == '0) ? bea_pkg::COUNT_W'(1) : rep_period;
  end

  // Write back the new state of the button.
  always_ff @(posedge clk) begin
    if (cmd.calc && item_in_range) begin
      mem[item_addr] <= {item_level, count_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.calc && item_in_range) begin
      entry_valid[item_addr] <= 1'b1;
    end
  end

  // The repeat phase needs count modulo interval from the serial unit.
  assign div_start = cmd.calc & item_in_range & past_delay;

  bea_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (count_next),
    .divisor   (divisor),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Result fields; an out-of-range index gives an all-zero result.
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      res_level <= item_in_range & item_level;
      res_rose <= item_in_range & rose_c;
      res_fell <= item_in_range & fell_c;
      res_held <= item_in_range & held_c;
      res_pulse <= item_in_range & rose_c;
    end else if (div_done) begin
      res_pulse <= (div_rem == '0);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pressed_now <= res_level;
      rose <= res_rose;
      fell <= res_fell;
      repeat_pulse <= res_pulse;
      repeat_held <= res_held;
    end
  end

  assign status.need_div = div_start;
  assign status.div_done = div_done;

endmodule

>>> design/bea_ctrl.sv
// Controller: sequences each item through read, update, remainder and output.
module bea_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bea_pkg::status_t  status,
  output bea_pkg::cmd_t     cmd
);

  bea_pkg::state_t state;
  bea_pkg::state_t state_next;
  logic            out_free;

  // State register and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bea_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_free = ~out_valid | out_ready;

  // Next state and commands.
  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    cmd = '0;
    unique case (state)
      bea_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_item = 1'b1;
          state_next = bea_pkg::S_CALC;
        end
      end
      bea_pkg::S_CALC: begin
        cmd.calc = 1'b1;
        state_next = status.need_div ? bea_pkg::S_DIV : bea_pkg::S_HOLD;
      end
      bea_pkg::S_DIV: begin
        if (status.div_done) begin
          state_next = bea_pkg::S_HOLD;
        end
      end
      bea_pkg::S_HOLD: begin
        // Hand the result over and take the next item in the same cycle.
        if (out_free) begin
          cmd.load_out = 1'b1;
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.take_item = 1'b1;
            state_next = bea_pkg::S_CALC;
          end else begin
            state_next = bea_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = bea_pkg::S_IDLE;
      end
    endcase
  end

  // An accepted item always goes to the update step next.
  a_take_then_calc: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == bea_pkg::S_CALC))
    else $error("accepted item did not reach the update step");

  // A finished remainder always leads to the result hold state.
  a_div_then_hold: assert property (@(posedge clk) disable iff (rst)
    (state == bea_pkg::S_DIV && status.div_done) |=> (state == bea_pkg::S_HOLD))
    else $error("remainder completion was missed");

  // A result is only loaded while the output register can take it.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("output register overwritten before transfer");

  // A load shows up as a valid result in the next cycle.
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

endmodule

>>> design/button_edge_autorepeat.sv
// Top level: per-button edge detection with typematic auto-repeat.
// A sample passes through the update step and, when the button is in its repeat phase,
// through the 15 steps of the serial remainder unit before its result is loaded.
// A new sample is accepted only once the last result has moved to the output register.
// The output register lets the next sample enter while a result waits.
// Reset (synchronous, rst high) marks every button released with count zero at once
// through per-entry valid bits, and loads a start delay of 24 and a repeat period of 12.
module button_edge_autorepeat (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [bea_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bea_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bea_pkg::INDEX_W-1:0]      button_index,
  input  logic                             button_pressed,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             pressed_now,
  output logic                             rose,
  output logic                             fell,
  output logic                             repeat_pulse,
  output logic                             repeat_held
);

  bea_pkg::cmd_t    cmd;
  bea_pkg::status_t status;

  bea_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bea_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .button_index   (button_index),
    .button_pressed (button_pressed),
    .pressed_now    (pressed_now),
    .rose           (rose),
    .fell           (fell),
    .repeat_pulse   (repeat_pulse),
    .repeat_held    (repeat_held)
  );

endmodule

>>> dv/bea_checker.sv
// Result checker for the button edge and auto-repeat block: predicts and compares each result.
`timescale 1ns / 1ps
module bea_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [bea_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bea_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [bea_pkg::INDEX_W-1:0]     button_index,
  input  logic                            button_pressed,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            pressed_now,
  input  logic                            rose,
  input  logic                            fell,
  input  logic                            repeat_pulse,
  input  logic                            repeat_held,
  output int                              fail_count,
  output int                              pending
);

  typedef struct packed {
    logic pressed_now;
    logic rose;
    logic fell;
    logic repeat_pulse;
    logic repeat_held;
  } sample_result_t;

  // Predicted per-button state and register copies.
  logic                           last_level [bea_pkg::NUM_BUTTONS];
  logic [bea_pkg::COUNT_W-1:0]    hold_polls [bea_pkg::NUM_BUTTONS];
  logic [bea_pkg::CFG_DATA_W-1:0] delay_cfg;
  logic [bea_pkg::CFG_DATA_W-1:0] interval_cfg;
  sample_result_t                 expected_results [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // Works out the result of one sample and advances that button's state.
  function automatic sample_result_t predict_sample(logic [bea_pkg::INDEX_W-1:0] idx, logic lvl);
    sample_result_t                 r;
    logic                           prev;
    logic [bea_pkg::COUNT_W:0]      count;
    logic [bea_pkg::CFG_DATA_W-1:0] step;
    r = '0;
    if (int'(idx) >= bea_pkg::NUM_BUTTONS) return r;
    prev = last_level[idx];
    r.pressed_now = lvl;
    r.rose = lvl & ~prev;
    r.fell = prev & ~lvl;
    last_level[idx] = lvl;
    if (r.rose) begin
      hold_polls[idx] = '0;
      r.repeat_pulse = 1'b1;
      r.repeat_held = 1'b1;
    end else if (lvl) begin
      count = {1'b0, hold_polls[idx]} + 1'b1;
      if (count > {1'b0, bea_pkg::COUNT_LIMIT}) count = '0;
      hold_polls[idx] = count[bea_pkg::COUNT_W-1:0];
      if (count > {1'b0, delay_cfg}) begin
        // A zero interval behaves as one, so every held poll pulses.
        step = (interval_cfg == '0) ? bea_pkg::CFG_DATA_W'(1) : interval_cfg;
        r.repeat_pulse = ((count % {1'b0, step}) == '0);
        r.repeat_held = 1'b1;
      end
    end else if (r.fell) begin
      hold_polls[idx] = '0;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic want, logic got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0b actual %0b", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Track register writes, predict on input transfers, compare on output transfers.
  always @(posedge clk) begin
    sample_result_t got;
    sample_result_t want;
    if (rst) begin
      for (int i = 0; i < bea_pkg::NUM_BUTTONS; i++) begin
        last_level[i] = 1'b0;
        hold_polls[i] = '0;
      end
      delay_cfg = bea_pkg::START_DELAY_RESET;
      interval_cfg = bea_pkg::REP_PERIOD_RESET;
      expected_results.delete();
      pending <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          bea_pkg::REG_START_DELAY: delay_cfg = cfg_data;
          bea_pkg::REG_REP_PERIOD:  interval_cfg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = {pressed_now, rose, fell, repeat_pulse, repeat_held};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %b", $time, got);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("pressed_now", want.pressed_now, got.pressed_now);
          check_field("rose", want.rose, got.rose);
          check_field("fell", want.fell, got.fell);
          check_field("repeat_pulse", want.repeat_pulse, got.repeat_pulse);
          check_field("repeat_held", want.repeat_held, got.repeat_held);
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_sample(button_index, button_pressed));
      end
      pending <= expected_results.size();
    end
  end

endmodule

>>> dv/tb.sv
// Testbench top for the button edge and auto-repeat block: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_write = 1'b0;
  logic [bea_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [bea_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [bea_pkg::INDEX_W-1:0]     button_index = '0;
  logic                            button_pressed = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            pressed_now;
  logic                            rose;
  logic                            fell;
  logic                            repeat_pulse;
  logic                            repeat_held;
  int                              fail_count;
  int                              pending;
  int                              in_idle_max = 0;
  int                              out_idle_max = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  button_edge_autorepeat DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .button_index(button_index), .button_pressed(button_pressed),
    .out_valid(out_valid), .out_ready(out_ready),
    .pressed_now(pressed_now), .rose(rose), .fell(fell),
    .repeat_pulse(repeat_pulse), .repeat_held(repeat_held)
  );

  bea_checker bea_check (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .button_index(button_index), .button_pressed(button_pressed),
    .out_valid(out_valid), .out_ready(out_ready),
    .pressed_now(pressed_now), .rose(rose), .fell(fell),
    .repeat_pulse(repeat_pulse), .repeat_held(repeat_held),
    .fail_count(fail_count), .pending(pending)
  );

  // Offers one sample after a random gap and holds it until the transfer.
  task automatic send_sample(logic [bea_pkg::INDEX_W-1:0] idx, logic lvl);
    int gap;
    gap = $urandom_range(0, in_idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    button_index <= idx;
    button_pressed <= lvl;
    do @(posedge clk); while (!in_ready);
  endtask

  // Holds off the sender until every predicted result has arrived, then lets the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  // Writes both timing registers on consecutive cycles while the block is idle.
  task automatic set_timing(logic [bea_pkg::CFG_DATA_W-1:0] delay,
                            logic [bea_pkg::CFG_DATA_W-1:0] interval);
    cfg_write <= 1'b1;
    cfg_index <= bea_pkg::REG_START_DELAY;
    cfg_data <= delay;
    @(posedge clk);
    cfg_index <= bea_pkg::REG_REP_PERIOD;
    cfg_data <= interval;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Mostly press-hold-release runs on a few buttons, with random samples mixed in.
  task automatic run_phase(int p, logic [bea_pkg::CFG_DATA_W-1:0] delay,
                           logic [bea_pkg::CFG_DATA_W-1:0] interval, int items);
    logic [bea_pkg::INDEX_W-1:0] focus [4];
    int                          hold_left [4];
    int                          k;
    drain();
    set_timing(delay, interval);
    in_idle_max = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 3 : 10);
    out_idle_max = (p % 2 == 0) ? 10 : ((p % 4 == 1) ? 0 : 4);
    foreach (focus[i]) begin
      focus[i] = bea_pkg::INDEX_W'($urandom_range(0, bea_pkg::NUM_BUTTONS - 1));
      hold_left[i] = 0;
    end
    repeat (items) begin
      k = $urandom_range(0, 3);
      if ($urandom_range(0, 9) >= 8) begin
        send_sample(bea_pkg::INDEX_W'($urandom_range(0, bea_pkg::NUM_BUTTONS - 1)),
                    1'($urandom_range(0, 1)));
      end else if (hold_left[k] > 0) begin
        send_sample(focus[k], 1'b1);
        hold_left[k]--;
      end else begin
        send_sample(focus[k], 1'b0);
        if ($urandom_range(0, 2) != 0) hold_left[k] = $urandom_range(1, 60);
      end
    end
  endtask

  // The receiver stalls a random number of cycles before taking each result.
  initial begin
    int stall;
    wait (!rst);
    forever begin
      stall = $urandom_range(0, out_idle_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Main stimulus sequence.
  initial begin
    logic [bea_pkg::CFG_DATA_W-1:0] delays [8];
    logic [bea_pkg::CFG_DATA_W-1:0] intervals [8];
    delays = '{15'd24, 15'd0, 15'd3, 15'd30000, 15'd0, 15'd7, 15'd2, 15'd0};
    intervals = '{15'd12, 15'd1, 15'd2, 15'd30000, 15'd0, 15'd5, 15'h7FFF, 15'd1};
    delays[7] = bea_pkg::CFG_DATA_W'($urandom_range(0, 40));
    intervals[7] = bea_pkg::CFG_DATA_W'($urandom_range(1, 16));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero delay with zero interval, idle, press, hold, release on both end buttons.
    set_timing(15'd0, 15'd0);
    send_sample(7'd0, 1'b0);
    send_sample(7'd0, 1'b1);
    repeat (3) send_sample(7'd0, 1'b1);
    send_sample(7'd0, 1'b0);
    send_sample(7'd0, 1'b0);
    send_sample(7'd127, 1'b1);
    send_sample(7'd127, 1'b1);
    send_sample(7'd127, 1'b0);
    send_sample(7'd127, 1'b0);
    send_sample(7'd127, 1'b1);
    send_sample(7'd127, 1'b1);

    // Directed: a long hold on one button through several repeat instants.
    drain();
    set_timing(15'd0, 15'd7);
    send_sample(7'd85, 1'b1);
    repeat (40) send_sample(7'd85, 1'b1);
    send_sample(7'd85, 1'b0);

    // Random phases across several register settings, extremes included.
    for (int p = 0; p < 8; p++) begin
      run_phase(p, delays[p], intervals[p], 230);
    end

    drain();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
